[rtl/assert_macros.svh]
// assertion macros used by mandelbrot_escape_count.sv
// needs a clk and an active-low rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/mec_pkg.sv]
// shared types and constants for the escape-time counter
// no dependencies
package mec_pkg;

  localparam int PIX_W  = 10;  // pixel coordinate width
  localparam int DIM_W  = 11;  // image dimension register width
  localparam int ITER_W = 12;  // iteration limit register and count field width
  localparam int SUM_W  = 32;  // checksum width
  localparam int CFG_W  = 12;  // config write data width, widest config register
  localparam int CFG_IDX_W = 2;

  // real axis: x * 3.5 / w - 2.5, held as x * 7 * 2^(f-1) / w - 5 * 2^(f-1)
  localparam int RE_SPAN_X2 = 7;
  localparam int RE_OFF_X2  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ITERS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_DONE
  } state_t;

endpackage

[rtl/mandelbrot_escape_count.sv]
// escape-time counter top level: sequencer, shared divider and multiplier, checksum
// depends on mec_pkg and assert_macros.svh
//
// One pixel is taken per transfer and one result is given back for it. After a pixel is
// accepted, a one-bit-per-cycle restoring divider forms the real part of c and then the
// imaginary part. The escape loop then runs on a single shared signed multiplier, one state
// per step of an iteration (zr*zr, zi*zi, then the escape test together with zr*zi and the
// z update). The limit, 100 after reset, is tested in the zr*zr step and ends the pixel
// there; an escape ends it in the last step. The finished result waits until the output
// register is free. The input is ready only while the sequencer is idle; the finished
// result sits in an output register, so the next pixel may be accepted while that result
// still waits to be taken. Image dimensions of 0 act as 1 and dimensions above MAX_DIM act
// as MAX_DIM; c saturates to the signed Q4.FRAC_BITS range. The checksum is the saturating
// sum of counts since the last pixel with clear_sum set, and is cleared by reset.
`include "assert_macros.svh"

module mandelbrot_escape_count
  import mec_pkg::*;
#(
  parameter int MAX_DIM   = 1024,
  parameter int FRAC_BITS = 28,
  parameter int ITER_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // pixel input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
  input  logic                 in_tuser,   // clear_sum
  // result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata   // iteration_count[11:0], checksum[43:12], zero pad
);

  localparam int WORD_W = FRAC_BITS + 4;          // Q4.F word
  localparam int PROD_W = 2 * WORD_W;
  localparam int SQ_W   = FRAC_BITS + 8;          // product shifted down by F
  localparam int Z_W    = SQ_W + 2;               // room for the z update sums
  localparam int NUM_W  = PIX_W + 3 + FRAC_BITS - 1;  // divider numerator / quotient
  localparam int CDIF_W = NUM_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam logic signed [CDIF_W-1:0] OFF_RE = CDIF_W'(RE_OFF_X2) << (FRAC_BITS - 1);
  localparam logic signed [CDIF_W-1:0] OFF_IM = CDIF_W'(1) << FRAC_BITS;
  localparam logic signed [SQ_W:0]     ESC    = (SQ_W + 1)'(4) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] FX_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] FX_MIN = {1'b1, {(WORD_W - 1){1'b0}}};
  localparam logic [15:0]              ITER_MASK = 16'((32'd1 << ITER_BITS) - 1);
  localparam logic [DCNT_W-1:0]        DIV_LAST  = DCNT_W'(NUM_W - 1);

  // saturate the divider result minus its offset into a Q4.F word
  function automatic logic signed [WORD_W-1:0] sat_c(input logic signed [CDIF_W-1:0] v);
    logic [CDIF_W-WORD_W:0] top;
    top = v[CDIF_W-1:WORD_W-1];
    if ((&top) || !(|top)) return v[WORD_W-1:0];
    else if (v[CDIF_W-1]) return FX_MIN;
    else return FX_MAX;
  endfunction

  // saturate a z update sum into a Q4.F word
  function automatic logic signed [WORD_W-1:0] sat_z(input logic signed [Z_W-1:0] v);
    logic [Z_W-WORD_W:0] top;
    top = v[Z_W-1:WORD_W-1];
    if ((&top) || !(|top)) return v[WORD_W-1:0];
    else if (v[Z_W-1]) return FX_MIN;
    else return FX_MAX;
  endfunction

  // clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    else if (32'(d) > MAX_DIM) return DIM_W'(MAX_DIM);
    else return d;
  endfunction

  // ---------------------------------------------------------------- registers
  state_t state_r, state_nxt;

  logic [DIM_W-1:0]  width_r, height_r;
  logic [ITER_W-1:0] iters_r;

  logic [PIX_W-1:0]  py_r, py_nxt;
  logic              clr_r, clr_nxt;

  // shared divider
  logic [NUM_W-1:0]  num_r, num_nxt;     // numerator in, quotient out
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [DIM_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  // escape loop
  logic signed [WORD_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [WORD_W-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [SQ_W-1:0]   sr_r, sr_nxt, si_r, si_nxt;
  logic [ITER_BITS-1:0]     count_r, count_nxt;

  // result side
  logic              out_valid_r, out_valid_nxt;
  logic [ITER_W-1:0] out_count_r, out_count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // ---------------------------------------------------------------- handshake decode
  logic in_xfer, out_xfer, out_free, load_out;
  logic div_last;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_valid_r && out_tready;
  assign out_free = !out_valid_r || out_tready;
  assign div_last = (dcnt_r == DIV_LAST);

  // ---------------------------------------------------------------- shared divider step
  logic [DIM_W:0]   trial;
  logic             q_bit;
  logic [NUM_W-1:0] num_step;
  logic [DIM_W-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, num_r[NUM_W-1]};
    q_bit    = (trial >= {1'b0, dvs_r});
    rem_step = q_bit ? DIM_W'(trial - {1'b0, dvs_r}) : DIM_W'(trial);
    num_step = {num_r[NUM_W-2:0], q_bit};
  end

  // quotient minus the axis offset, saturated into c
  logic signed [WORD_W-1:0] c_sat;
  always_comb begin
    if (state_r == ST_DIV_RE) c_sat = sat_c($signed({1'b0, num_step}) - OFF_RE);
    else c_sat = sat_c($signed({1'b0, num_step}) - OFF_IM);
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SQ_W-1:0]   prod_sq;
  logic signed [SQ_W:0]     prod_cross;   // 2*a*b shifted down by F

  always_comb begin
    case (state_r)
      ST_MUL_RR: begin mul_a = zr_r; mul_b = zr_r; end
      ST_MUL_II: begin mul_a = zi_r; mul_b = zi_r; end
      default:   begin mul_a = zr_r; mul_b = zi_r; end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign prod_sq    = prod[PROD_W-1:FRAC_BITS];
  assign prod_cross = prod[PROD_W-1:FRAC_BITS-1];

  // escape test and z update
  logic signed [SQ_W:0]  mag2;
  logic                  escaped;
  logic signed [Z_W-1:0] zr_wide, zi_wide;
  logic [ITER_BITS-1:0]  limit;
  logic                  at_limit;

  assign mag2     = (SQ_W + 1)'(sr_r) + (SQ_W + 1)'(si_r);
  assign escaped  = (mag2 > ESC);
  assign zr_wide  = Z_W'(sr_r) - Z_W'(si_r) + Z_W'(cr_r);
  assign zi_wide  = Z_W'(prod_cross) + Z_W'(ci_r);
  assign limit    = ITER_BITS'(16'(iters_r) & ITER_MASK);
  assign at_limit = (count_r == limit);

  // checksum add with saturation
  logic [SUM_W-1:0] sum_base;
  logic [SUM_W:0]   sum_wide;
  assign sum_base = clr_r ? '0 : sum_r;
  assign sum_wide = (SUM_W + 1)'(sum_base) + (SUM_W + 1)'(count_r);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DIV_RE;
      ST_DIV_RE: if (div_last) state_nxt = ST_DIV_IM;
      ST_DIV_IM: if (div_last) state_nxt = ST_MUL_RR;
      ST_MUL_RR: state_nxt = at_limit ? ST_DONE : ST_MUL_II;
      ST_MUL_II: state_nxt = ST_MUL_RI;
      ST_MUL_RI: state_nxt = escaped ? ST_DONE : ST_MUL_RR;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: load_out  = out_free;
      default: begin
        in_tready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    py_nxt    = py_r;
    clr_nxt   = clr_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    dcnt_nxt  = dcnt_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    sr_nxt    = sr_r;
    si_nxt    = si_r;
    count_nxt = count_r;

    if (in_xfer) begin
      // real axis numerator x * 7 * 2^(f-1)
      num_nxt  = (NUM_W'(in_tdata[PIX_W-1:0]) * NUM_W'(RE_SPAN_X2)) << (FRAC_BITS - 1);
      py_nxt   = in_tdata[2*PIX_W-1:PIX_W];
      clr_nxt  = in_tuser;
      rem_nxt  = '0;
      dvs_nxt  = clamp_dim(width_r);
      dcnt_nxt = '0;
    end

    case (state_r)
      ST_DIV_RE: begin
        num_nxt  = num_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + 1'b1;
        if (div_last) begin
          cr_nxt   = c_sat;
          // imaginary axis numerator y * 2^(f+1)
          num_nxt  = NUM_W'(py_r) << (FRAC_BITS + 1);
          rem_nxt  = '0;
          dvs_nxt  = clamp_dim(height_r);
          dcnt_nxt = '0;
        end
      end
      ST_DIV_IM: begin
        num_nxt  = num_step;
        rem_nxt  = rem_step;
        dcnt_nxt = dcnt_r + 1'b1;
        if (div_last) begin
          ci_nxt    = c_sat;
          zr_nxt    = '0;
          zi_nxt    = '0;
          count_nxt = '0;
          dcnt_nxt  = '0;
        end
      end
      ST_MUL_RR: sr_nxt = prod_sq;
      ST_MUL_II: si_nxt = prod_sq;
      ST_MUL_RI: begin
        if (!escaped) begin
          zr_nxt    = sat_z(zr_wide);
          zi_nxt    = sat_z(zi_wide);
          count_nxt = count_r + 1'b1;
        end
      end
      default: begin
        sr_nxt = sr_r;
      end
    endcase
  end

  // result register and checksum
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    sum_nxt       = sum_r;
    if (out_xfer) out_valid_nxt = 1'b0;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = ITER_W'(16'(count_r));
      sum_nxt       = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= DIM_W'(128);
      height_r    <= DIM_W'(128);
      iters_r     <= ITER_W'(100);
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      dcnt_r      <= dcnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
          CFG_ITERS:  iters_r  <= cfg_wdata[ITER_W-1:0];
          default:    iters_r  <= iters_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    py_r        <= py_nxt;
    clr_r       <= clr_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    sr_r        <= sr_nxt;
    si_r        <= si_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, sum_r, out_count_r};

  // ---------------------------------------------------------------- assertions
  `ASSERT_PROP(a_accept_starts_div, in_xfer |=> (state_r == ST_DIV_RE),
               "accepted pixel did not start the divider")
  `ASSERT_NEVER(a_load_over_held, load_out && out_valid_r && !out_tready,
                "result overwrote a waiting transfer")
  `ASSERT_PROP(a_sum_grows, (load_out && !clr_r) |=> (sum_r >= $past(sum_r)),
               "checksum dropped without a clear")
  `ASSERT_NEVER(a_count_past_limit,
                ((state_r == ST_MUL_RR) || (state_r == ST_MUL_II) ||
                 (state_r == ST_MUL_RI)) && (count_r > limit),
                "iteration count ran past the limit")

endmodule
